// ----- hw/rtl/tbs_pkg.sv -----
// ----------------------------------------------------------------------------
// tbs_pkg: shared types and constants of the Tanimoto similarity block
// Holds the fixed-point constants of the ratio and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tbs_pkg;

    // Fixed input word width carried on the stream bus.
    localparam int IN_W   = 32;
    // Number of fraction bits of the Q1.16 ratio.
    localparam int FRAC_W = 16;
    // Width of the ratio field; also the number of divider steps.
    localparam int Q_W    = 17;
    // Width of a count field on the result bus.
    localparam int OUT_CNT_W = 11;
    // Width of the divider step counter.
    localparam int STEP_W = 5;
    // Width of one word's popcount.
    localparam int POP_W  = 6;

    typedef struct packed {
        logic acc_en;    // add the current word pair into the running counts
        logic capture;   // last word: freeze the final counts, clear the counters
        logic prep;      // form the total and load the divider
        logic div_step;  // one restoring division step
        logic load_out;  // move the finished result into the output register
    } tbs_cmd_t;

    typedef struct packed {
        logic out_valid; // the output register holds an item not yet taken
    } tbs_status_t;

endpackage

// ----- hw/rtl/tbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbs_ctrl: sequencer of the Tanimoto similarity block
// Accepts word pairs, then steps the divider once per quotient bit and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module tbs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_last,
    input  logic                 m_ready,
    input  tbs_pkg::tbs_status_t status,
    output logic                 s_ready,
    output tbs_pkg::tbs_cmd_t    cmd
);

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [tbs_pkg::STEP_W-1:0] LAST_STEP = tbs_pkg::STEP_W'(tbs_pkg::Q_W - 1);

    logic [1:0]                state_reg, state_next;
    logic [tbs_pkg::STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_ACC: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
                if (s_valid && s_last) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.out_valid || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- hw/rtl/tbs_dp.sv -----
// ----------------------------------------------------------------------------
// tbs_dp: datapath of the Tanimoto similarity block
// Popcounts and saturating counters, final count snapshot, a bit-serial
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module tbs_dp #(
    parameter int MAX_BITS  = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tbs_pkg::tbs_cmd_t                      cmd,
    input  logic [tbs_pkg::IN_W-1:0]               word_a,
    input  logic [tbs_pkg::IN_W-1:0]               word_b,
    input  logic                                   m_ready,
    output tbs_pkg::tbs_status_t                   status,
    output logic                                   m_valid,
    output logic [tbs_pkg::Q_W-1:0]                similarity,
    output logic [tbs_pkg::OUT_CNT_W-1:0]          bits_both,
    output logic [tbs_pkg::OUT_CNT_W-1:0]          bits_only_a,
    output logic [tbs_pkg::OUT_CNT_W-1:0]          bits_only_b,
    output logic                                   all_zero,
    output logic                                   overflowed
);

    localparam int CNT_W = $clog2(MAX_BITS + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int TOT_W = CNT_W + 2;
    localparam int NUM_W = CNT_W + tbs_pkg::Q_W;
    localparam int Q_W   = tbs_pkg::Q_W;
    localparam int OC_W  = tbs_pkg::OUT_CNT_W;
    localparam logic [SUM_W-1:0] SAT_LIM = SUM_W'(MAX_BITS);
    localparam logic [Q_W-1:0]   Q_ONE   = Q_W'(1) << tbs_pkg::FRAC_W;

    // Only the low WORD_BITS bits of a word take part.
    logic [tbs_pkg::IN_W-1:0] mask;
    always_comb begin
        for (int i = 0; i < tbs_pkg::IN_W; i++) begin
            mask[i] = (i < WORD_BITS);
        end
    end

    logic [tbs_pkg::IN_W-1:0] a_m, b_m, both_w, only_a_w, only_b_w;
    assign a_m      = word_a & mask;
    assign b_m      = word_b & mask;
    assign both_w   = a_m & b_m;
    assign only_a_w = a_m & ~both_w;
    assign only_b_w = b_m & ~both_w;

    logic [tbs_pkg::POP_W-1:0] pop_both, pop_a, pop_b;
    always_comb begin
        pop_both = '0;
        pop_a    = '0;
        pop_b    = '0;
        for (int i = 0; i < tbs_pkg::IN_W; i++) begin
            pop_both = pop_both + tbs_pkg::POP_W'(both_w[i]);
            pop_a    = pop_a    + tbs_pkg::POP_W'(only_a_w[i]);
            pop_b    = pop_b    + tbs_pkg::POP_W'(only_b_w[i]);
        end
    end

    // Running counts and saturation flag.
    logic [CNT_W-1:0] cnt_both_reg, cnt_a_reg, cnt_b_reg;
    logic [CNT_W-1:0] cnt_both_next, cnt_a_next, cnt_b_next;
    logic             sat_reg, sat_next;
    logic [SUM_W-1:0] sum_both, sum_a, sum_b;
    logic             ov_both, ov_a, ov_b;

    assign sum_both = {1'b0, cnt_both_reg} + SUM_W'(pop_both);
    assign sum_a    = {1'b0, cnt_a_reg}    + SUM_W'(pop_a);
    assign sum_b    = {1'b0, cnt_b_reg}    + SUM_W'(pop_b);
    assign ov_both  = sum_both > SAT_LIM;
    assign ov_a     = sum_a    > SAT_LIM;
    assign ov_b     = sum_b    > SAT_LIM;
    assign cnt_both_next = ov_both ? CNT_W'(MAX_BITS) : sum_both[CNT_W-1:0];
    assign cnt_a_next    = ov_a    ? CNT_W'(MAX_BITS) : sum_a[CNT_W-1:0];
    assign cnt_b_next    = ov_b    ? CNT_W'(MAX_BITS) : sum_b[CNT_W-1:0];
    assign sat_next      = sat_reg | ov_both | ov_a | ov_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_both_reg <= '0;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            sat_reg      <= 1'b0;
        end else if (cmd.acc_en) begin
            if (cmd.capture) begin
                cnt_both_reg <= '0;
                cnt_a_reg    <= '0;
                cnt_b_reg    <= '0;
                sat_reg      <= 1'b0;
            end else begin
                cnt_both_reg <= cnt_both_next;
                cnt_a_reg    <= cnt_a_next;
                cnt_b_reg    <= cnt_b_next;
                sat_reg      <= sat_next;
            end
        end
    end

    // Final counts of one fingerprint.
    logic [CNT_W-1:0] fin_both_reg, fin_a_reg, fin_b_reg;
    logic             fin_sat_reg;

    always_ff @(posedge aclk) begin
        if (cmd.acc_en && cmd.capture) begin
            fin_both_reg <= cnt_both_next;
            fin_a_reg    <= cnt_a_next;
            fin_b_reg    <= cnt_b_next;
            fin_sat_reg  <= sat_next;
        end
    end

    // Rounded numerator and divider setup.
    logic [TOT_W-1:0] total;
    logic [NUM_W-1:0] numer;
    assign total = TOT_W'(fin_both_reg) + TOT_W'(fin_a_reg) + TOT_W'(fin_b_reg);
    assign numer = (NUM_W'(fin_both_reg) << tbs_pkg::FRAC_W) + NUM_W'(total >> 1);

    // The quotient fits in Q_W bits, so the numerator bits above them are
    // already below the divisor and seed the remainder directly.
    logic [TOT_W-1:0] tot_reg, rem_reg;
    logic [Q_W-1:0]   nbits_reg, quo_reg;
    logic [TOT_W:0]   trial;
    logic             q_bit;

    assign trial = {rem_reg, nbits_reg[Q_W-1]};
    assign q_bit = trial >= {1'b0, tot_reg};

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            tot_reg   <= total;
            rem_reg   <= TOT_W'(numer[NUM_W-1:Q_W]);
            nbits_reg <= numer[Q_W-1:0];
            quo_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_reg   <= q_bit ? TOT_W'(trial - {1'b0, tot_reg}) : trial[TOT_W-1:0];
            nbits_reg <= {nbits_reg[Q_W-2:0], 1'b0};
            quo_reg   <= {quo_reg[Q_W-2:0], q_bit};
        end
    end

    // Result formatting and output register.
    logic             zero_tot;
    logic [Q_W-1:0]   sim_val;
    logic [CNT_W+OC_W-1:0] both_ext, a_ext, b_ext;

    assign zero_tot = (tot_reg == '0);
    assign sim_val  = zero_tot ? '0 : ((quo_reg > Q_ONE) ? Q_ONE : quo_reg);
    assign both_ext = {{OC_W{1'b0}}, fin_both_reg};
    assign a_ext    = {{OC_W{1'b0}}, fin_a_reg};
    assign b_ext    = {{OC_W{1'b0}}, fin_b_reg};

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            similarity  <= sim_val;
            bits_both   <= both_ext[OC_W-1:0];
            bits_only_a <= a_ext[OC_W-1:0];
            bits_only_b <= b_ext[OC_W-1:0];
            all_zero    <= zero_tot;
            overflowed  <= fin_sat_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign status.out_valid = m_valid_reg;

endmodule

// ----- hw/rtl/tanimoto_bit_similarity.sv -----
// ----------------------------------------------------------------------------
// tanimoto_bit_similarity: Tanimoto coefficient of two bit fingerprints
// Streams word pairs of two fingerprints and reports their Tanimoto ratio
// in unsigned Q1.16 together with the three bit counts.
// ----------------------------------------------------------------------------
// Word pairs of fingerprints A and B enter on the slave stream, one per cycle
// while s_axis_tready is high, the final pair marked by s_axis_tlast. Only
// the low WORD_BITS bits of each 32-bit word count. Three saturating counters
// track bits set in both, only in A and only in B; a count that would pass
// MAX_BITS is clipped there and flagged as overflowed. After the last pair
// the block forms the rounded numerator both*65536 + total/2 and loads the
// bit-serial restoring divider, which produces one quotient bit a cycle, and
// then loads the output register. s_axis_tready stays low from a last word
// until that load. The result waits in its own register, so the next
// fingerprint streams in while a result is still unclaimed; the block only
// stalls at the end of that next fingerprint if the old result is still held.
// Fingerprints with no bit set report a ratio of zero with the all-zero flag.
module tanimoto_bit_similarity #(
    parameter int MAX_BITS  = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave stream: one word pair per item.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] word_a, [63:32] word_b
    input  logic        s_axis_tlast,  // last_word
    // Master stream: one result per fingerprint.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [16:0] similarity, [27:17] bits_both,
                                       // [38:28] bits_only_a, [49:39] bits_only_b,
                                       // [55:50] zero fill
    output logic [1:0]  m_axis_tuser   // [0] all_zero, [1] overflowed
);

    tbs_pkg::tbs_cmd_t    cmd;
    tbs_pkg::tbs_status_t status;

    logic [tbs_pkg::Q_W-1:0]       similarity;
    logic [tbs_pkg::OUT_CNT_W-1:0] bits_both, bits_only_a, bits_only_b;
    logic                          all_zero, overflowed;

    // The sequencer decides when words are taken and when the divider runs.
    tbs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_last  (s_axis_tlast),
        .m_ready (m_axis_tready),
        .status  (status),
        .s_ready (s_axis_tready),
        .cmd     (cmd)
    );

    // Counters, divider and output register.
    tbs_dp #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .word_a      (s_axis_tdata[31:0]),
        .word_b      (s_axis_tdata[63:32]),
        .m_ready     (m_axis_tready),
        .status      (status),
        .m_valid     (m_axis_tvalid),
        .similarity  (similarity),
        .bits_both   (bits_both),
        .bits_only_a (bits_only_a),
        .bits_only_b (bits_only_b),
        .all_zero    (all_zero),
        .overflowed  (overflowed)
    );

    assign m_axis_tdata = {6'b0, bits_only_b, bits_only_a, bits_both, similarity};
    assign m_axis_tuser = {overflowed, all_zero};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tanimoto_bit_similarity
// A table of directed fingerprints, then random word pairs grouped into
// fingerprints of random length and shape, about nine hundred items in all.
// Each result is compared with a local prediction of the counts, flags and
// Q1.16 ratio.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IN_W      = tbs_pkg::IN_W;
    localparam int Q_W       = tbs_pkg::Q_W;
    localparam int OUT_CNT_W = tbs_pkg::OUT_CNT_W;
    localparam int FRAC_W    = tbs_pkg::FRAC_W;

    localparam int MAX_BITS     = 1024;
    localparam int WORD_BITS    = 32;
    localparam int CLK_HALF_NS  = 6;
    localparam int RESET_CYCLES = 6;
    // Random word pairs to send after the table.
    localparam int RANDOM_ITEMS = 710;
    // The last stretch of random pairs runs with no idling on either side.
    localparam int QUIET_TAIL   = 150;
    // After this many accepted items the receiver refuses results for a long stretch.
    localparam int PRESSURE_AT  = 300;
    localparam int LONG_HOLD    = 400;
    // Time to form the numerator, run the divider steps and load the output,
    // plus some slack for anything that comes out late.
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;
    // Far beyond the slowest correct run.
    localparam longint TIMEOUT_NS = 64'd250_000 * 2 * CLK_HALF_NS;
    localparam longint Q_ONE    = 64'd1 << FRAC_W;
    // Only the low WORD_BITS bits of a word are counted; WORD_BITS stays at or
    // below the bus width here.
    localparam logic [IN_W-1:0] WORD_MASK = {IN_W{1'b1}} >> (IN_W - WORD_BITS);

    // One result as the block reports it.
    typedef struct packed {
        logic [Q_W-1:0]       similarity;
        logic [OUT_CNT_W-1:0] bits_both;
        logic [OUT_CNT_W-1:0] bits_only_a;
        logic [OUT_CNT_W-1:0] bits_only_b;
        logic                 all_zero;
        logic                 overflowed;
    } tanimoto_result_t;

    // One row of the directed table: a word pair sent `repeats` times, where
    // only the final copy carries the last flag if the row asks for it.
    typedef struct packed {
        logic [IN_W-1:0]  word_a;
        logic [IN_W-1:0]  word_b;
        logic [7:0]       repeats;
        logic             last_word;
        logic             typed;
        tanimoto_result_t want;
    } stim_row_t;

    // Shapes of the random fingerprints.
    typedef enum int {
        FP_RANDOM,
        FP_EQUAL,
        FP_DENSE_BOTH,
        FP_DENSE_A,
        FP_DENSE_B,
        FP_SPARSE,
        FP_EXTREMES
    } fp_shape_t;

    logic              aclk;
    logic              aresetn;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata;   // [31:0] word_a, [63:32] word_b
    logic              s_axis_tlast;   // last_word
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [55:0]       m_axis_tdata;   // [16:0] similarity, [27:17] bits_both,
                                       // [38:28] bits_only_a, [49:39] bits_only_b
    logic [1:0]        m_axis_tuser;   // [0] all_zero, [1] overflowed

    tanimoto_bit_similarity #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Running counts of the fingerprint in flight, as the block should hold them.
    int run_both;
    int run_only_a;
    int run_only_b;
    bit run_clipped;

    // Results that the block still owes, oldest first.
    tanimoto_result_t awaited_results[$];
    stim_row_t        stim_table[$];

    int  items_sent;
    int  fault_count;
    bit  idling_on;

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF_NS aclk = ~aclk;
    end

    // The run is stopped here if the block hangs.
    initial begin
        #TIMEOUT_NS;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // A count that would pass MAX_BITS is held there and remembered as clipped.
    function automatic int clip_count(input int sum);
        if (sum > MAX_BITS) begin
            run_clipped = 1'b1;
            return MAX_BITS;
        end
        return sum;
    endfunction

    // Adds one word pair into the running counts. On a last word it forms
    // the result in `res`, clears the counts and returns 1; otherwise 0.
    function automatic bit tanimoto_step(input logic [IN_W-1:0] a,
                                         input logic [IN_W-1:0] b,
                                         input logic last,
                                         output tanimoto_result_t res);
        logic [IN_W-1:0] ma;
        logic [IN_W-1:0] mb;
        logic [IN_W-1:0] common;
        longint          total;
        longint          ratio;
        ma     = a & WORD_MASK;
        mb     = b & WORD_MASK;
        common = ma & mb;
        res    = '0;
        run_both   = clip_count(run_both + $countones(common));
        run_only_a = clip_count(run_only_a + $countones(ma & ~common));
        run_only_b = clip_count(run_only_b + $countones(mb & ~common));
        if (!last) begin
            return 1'b0;
        end
        total = longint'(run_both) + run_only_a + run_only_b;
        ratio = 0;
        // Round half up: add half the divisor before the division.
        if (total != 0) begin
            ratio = (longint'(run_both) * Q_ONE + total / 2) / total;
        end
        if (ratio > Q_ONE) begin
            ratio = Q_ONE;
        end
        res.similarity  = ratio[Q_W-1:0];
        res.bits_both   = run_both[OUT_CNT_W-1:0];
        res.bits_only_a = run_only_a[OUT_CNT_W-1:0];
        res.bits_only_b = run_only_b[OUT_CNT_W-1:0];
        res.all_zero    = (total == 0);
        res.overflowed  = run_clipped;
        run_both    = 0;
        run_only_a  = 0;
        run_only_b  = 0;
        run_clipped = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic tanimoto_result_t result_of(input int sim, input int both,
                                                   input int only_a, input int only_b,
                                                   input bit zero, input bit clipped);
        tanimoto_result_t r;
        r.similarity  = sim[Q_W-1:0];
        r.bits_both   = both[OUT_CNT_W-1:0];
        r.bits_only_a = only_a[OUT_CNT_W-1:0];
        r.bits_only_b = only_b[OUT_CNT_W-1:0];
        r.all_zero    = zero;
        r.overflowed  = clipped;
        return r;
    endfunction

    function automatic stim_row_t row_of(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                                         input int reps, input bit last, input bit typed,
                                         input tanimoto_result_t want);
        stim_row_t r;
        r.word_a    = a;
        r.word_b    = b;
        r.repeats   = reps[7:0];
        r.last_word = last;
        r.typed     = typed;
        r.want      = want;
        return r;
    endfunction

    // Appends one row at the end of the directed table.
    task automatic add_row(input stim_row_t r);
        stim_table.insert(stim_table.size(), r);
    endtask

    // A word with only a few bits set: the AND of three random words.
    function automatic logic [IN_W-1:0] sparse_word();
        return $urandom & $urandom & $urandom;
    endfunction

    function automatic logic [IN_W-1:0] extreme_word();
        case ($urandom_range(0, 2))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Offers one word pair and waits for the block to take it. When `typed`
    // is set, the given result is expected instead of the predicted one.
    task automatic send_pair(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                             input logic last, input bit typed,
                             input tanimoto_result_t want);
        tanimoto_result_t predicted;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        if (tanimoto_step(a, b, last, predicted)) begin
            awaited_results.insert(awaited_results.size(), typed ? want : predicted);
        end
    endtask

    // One fingerprint of random length and shape. Most are short; a few run to
    // 32 to 40 words so that dense shapes push the counts toward saturation.
    task automatic send_random_fingerprint(output int sent);
        int              len;
        int              pick;
        fp_shape_t       shape;
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            len = $urandom_range(1, 6);
        end else if (pick < 95) begin
            len = $urandom_range(7, 31);
        end else begin
            len = $urandom_range(32, 40);
        end
        shape = fp_shape_t'($urandom_range(FP_RANDOM, FP_EXTREMES));
        for (int i = 0; i < len; i++) begin
            case (shape)
                FP_EQUAL: begin
                    a = $urandom;
                    b = a;
                end
                FP_DENSE_BOTH: begin
                    a = ~sparse_word();
                    b = ~sparse_word();
                end
                FP_DENSE_A: begin
                    a = ~sparse_word();
                    b = sparse_word();
                end
                FP_DENSE_B: begin
                    a = sparse_word();
                    b = ~sparse_word();
                end
                FP_SPARSE: begin
                    // Half of these words are empty, so short fingerprints
                    // come out all zero now and then.
                    a = $urandom_range(0, 1) ? sparse_word() : '0;
                    b = $urandom_range(0, 1) ? sparse_word() : '0;
                end
                FP_EXTREMES: begin
                    a = extreme_word();
                    b = extreme_word();
                end
                default: begin
                    a = $urandom;
                    b = $urandom;
                end
            endcase
            send_pair(a, b, i == len - 1, 1'b0, '0);
        end
        sent = len;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : upstream
        int random_sent;
        int chunk;
        stim_row_t r;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        items_sent    = 0;
        fault_count   = 0;
        idling_on     = 1'b1;
        run_both      = 0;
        run_only_a    = 0;
        run_only_b    = 0;
        run_clipped   = 1'b0;
        random_sent   = 0;

        // Directed fingerprints. Rows with a typed result are whole
        // fingerprints whose outcome is plain from the bit patterns.
        add_row(row_of('0, '0, 1, 1'b1, 1'b1, result_of(0, 0, 0, 0, 1'b1, 1'b0)));
        add_row(row_of('1, '1, 1, 1'b1, 1'b1,
                       result_of(65536, 32, 0, 0, 1'b0, 1'b0)));
        add_row(row_of('1, '0, 1, 1'b1, 1'b1, result_of(0, 0, 32, 0, 1'b0, 1'b0)));
        add_row(row_of('0, '1, 1, 1'b1, 1'b1, result_of(0, 0, 0, 32, 1'b0, 1'b0)));
        add_row(row_of(32'hAAAA_AAAA, 32'h5555_5555, 1, 1'b1, 1'b1,
                       result_of(0, 0, 16, 16, 1'b0, 1'b0)));
        // A multi-word fingerprint with no bit set at all.
        add_row(row_of('0, '0, 5, 1'b1, 1'b1, result_of(0, 0, 0, 0, 1'b1, 1'b0)));
        // One bit in each class: a ratio of one third, rounded.
        add_row(row_of(32'h0000_0001, 32'h0000_0001, 1, 1'b0, 1'b0, '0));
        add_row(row_of(32'h0000_0002, 32'h0000_0000, 1, 1'b0, 1'b0, '0));
        add_row(row_of(32'h0000_0000, 32'h0000_0004, 1, 1'b1, 1'b0, '0));
        // A ratio of exactly one half, and two thirds that must round up.
        add_row(row_of(32'h8000_0000, 32'h8000_0001, 1, 1'b1, 1'b0, '0));
        add_row(row_of(32'h0000_0003, 32'h0000_0003, 1, 1'b0, 1'b0, '0));
        add_row(row_of(32'h0000_0004, 32'h0000_0000, 1, 1'b1, 1'b0, '0));
        add_row(row_of(32'h0000_FFFF, 32'h00FF_00FF, 1, 1'b1, 1'b0, '0));
        add_row(row_of(32'hDEAD_BEEF, 32'h0F0F_0F0F, 1, 1'b1, 1'b0, '0));
        // Counts landing exactly on the bound are valid and not flagged.
        add_row(row_of('1, '1, 32, 1'b1, 1'b1,
                       result_of(65536, 1024, 0, 0, 1'b0, 1'b0)));
        // Words past the bound saturate each count in turn.
        add_row(row_of('1, '1, 33, 1'b1, 1'b1,
                       result_of(65536, 1024, 0, 0, 1'b0, 1'b1)));
        add_row(row_of('1, '0, 40, 1'b1, 1'b1,
                       result_of(0, 0, 1024, 0, 1'b0, 1'b1)));
        add_row(row_of('0, '1, 33, 1'b1, 1'b1,
                       result_of(0, 0, 0, 1024, 1'b0, 1'b1)));
        // Only the shared count clips while the other one keeps counting.
        add_row(row_of(32'hFFFF_FFFF, 32'h7FFF_FFFF, 34, 1'b1, 1'b0, '0));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i]) begin
            r = stim_table[i];
            for (int k = 0; k < r.repeats; k++) begin
                send_pair(r.word_a, r.word_b, r.last_word && (k == r.repeats - 1),
                          r.typed, r.want);
            end
        end

        // Random fingerprints; the tail runs without idling.
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
                idling_on = 1'b0;
            end
            send_random_fingerprint(chunk);
            random_sent += chunk;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        // Any result that shows up now was never asked for.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random short stalls, one long hold-off that backs the block
    // up into its input, and no stalls at all during the quiet tail.
    // ------------------------------------------------------------------------
    initial begin : downstream
        int  hold_left;
        int  stall_left;
        bit  held_once;
        hold_left     = 0;
        stall_left    = 0;
        held_once     = 1'b0;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!held_once && items_sent >= PRESSURE_AT) begin
                held_once = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: every accepted result against the oldest awaited one.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        tanimoto_result_t got;
        tanimoto_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.similarity  = m_axis_tdata[16:0];
            got.bits_both   = m_axis_tdata[27:17];
            got.bits_only_a = m_axis_tdata[38:28];
            got.bits_only_b = m_axis_tdata[49:39];
            got.all_zero    = m_axis_tuser[0];
            got.overflowed  = m_axis_tuser[1];
            if (awaited_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("%0t: result with none awaited: sim=%0d both=%0d a=%0d b=%0d z=%0b o=%0b",
                             $realtime, got.similarity, got.bits_both, got.bits_only_a,
                             got.bits_only_b, got.all_zero, got.overflowed);
                end
            end else begin
                want = awaited_results.pop_front();
                if (got.similarity !== want.similarity || got.bits_both !== want.bits_both
                        || got.bits_only_a !== want.bits_only_a
                        || got.bits_only_b !== want.bits_only_b
                        || got.all_zero !== want.all_zero
                        || got.overflowed !== want.overflowed) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch expected sim=%0d both=%0d a=%0d b=%0d z=%0b o=%0b",
                                 $realtime, want.similarity, want.bits_both,
                                 want.bits_only_a, want.bits_only_b, want.all_zero,
                                 want.overflowed);
                        $display("%0t:          actual   sim=%0d both=%0d a=%0d b=%0d z=%0b o=%0b",
                                 $realtime, got.similarity, got.bits_both,
                                 got.bits_only_a, got.bits_only_b, got.all_zero,
                                 got.overflowed);
                    end
                end
            end
        end
    end

endmodule
